[rtl/firpow_pkg.sv]
// Shared types and fixed widths for the FIR filter with power output.
// No dependencies; compile first.
package firpow_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int COEF_W    = 16;
  localparam int IDX_W     = 5;
  localparam int FILT_W    = 18;
  localparam int POWER_W   = 32;
  localparam int MAG_W     = 18;
  localparam int FRAC_BITS = 15;
  // 13-bit signed sample times 16-bit signed coefficient
  localparam int PROD_W    = SAMPLE_W + 1 + COEF_W;
  localparam int FILT_MAX  = 131071;
  localparam int FILT_MIN  = -131072;

  localparam logic MODE_FILTER = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  typedef struct packed {
    logic load;   // accepted sample transaction: shift in and start the MAC pass
    logic wr_en;  // accepted coefficient transaction
  } mac_ctl_t;

endpackage

[rtl/firpow_if.sv]
// Valid/ready channel interfaces for the sample/coefficient input and the result output.
// Depends on firpow_pkg.
interface firpow_in_if;
  import firpow_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [SAMPLE_W-1:0]      sample;
  logic [IDX_W-1:0]         coef_index;
  logic signed [COEF_W-1:0] coef_value;

  modport source (output valid, mode, sample, coef_index, coef_value, input ready);
  modport sink   (input valid, mode, sample, coef_index, coef_value, output ready);
endinterface

interface firpow_out_if;
  import firpow_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [FILT_W-1:0] filtered;
  logic [POWER_W-1:0]       power;
  logic                     power_saturated;

  modport source (output valid, filtered, power, power_saturated, input ready);
  modport sink   (input valid, filtered, power, power_saturated, output ready);
endinterface

[rtl/firpow_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module firpow_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/firpow_mac.sv]
// Delay line, coefficient store and the shared tap-serial multiply-accumulate.
// Depends on firpow_pkg and firpow_ram.
module firpow_mac #(
  parameter int HIGHEST_TAP = 31
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  firpow_pkg::mac_ctl_t                ctl,
  input  logic [firpow_pkg::SAMPLE_W-1:0]     sample,
  input  logic [firpow_pkg::IDX_W-1:0]        coef_index,
  input  logic signed [firpow_pkg::COEF_W-1:0] coef_value,
  output logic                                done,
  output logic signed [firpow_pkg::PROD_W+$clog2(HIGHEST_TAP+1)-1:0] acc
);
  import firpow_pkg::*;

  localparam int TAP_COUNT = HIGHEST_TAP + 1;
  localparam int TAP_W     = $clog2(TAP_COUNT);
  localparam int ACC_W     = PROD_W + TAP_W;
  localparam int XIDX_W    = TAP_W + IDX_W;
  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(HIGHEST_TAP);

  logic [SAMPLE_W-1:0]      dl_r [TAP_COUNT];
  logic [TAP_COUNT-1:0]     cv_r;
  logic                     cv_q_r;
  logic                     run_r;
  logic                     drain_r;
  logic                     done_r;
  logic [TAP_W-1:0]         cnt_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic [XIDX_W-1:0]        idx_ext;
  logic                     idx_ok;
  logic                     wr_en;
  logic [TAP_W-1:0]         raddr;
  logic [COEF_W-1:0]        rdata;
  logic signed [COEF_W-1:0] coef_eff;
  logic signed [PROD_W-1:0] mult;

  assign idx_ext = {{TAP_W{1'b0}}, coef_index};
  assign idx_ok  = idx_ext < XIDX_W'(TAP_COUNT);
  assign wr_en   = ctl.wr_en && idx_ok;
  // next tap's coefficient is fetched ahead through the registered read; tap 0 while idle
  assign raddr   = (run_r && cnt_r != LAST_TAP) ? cnt_r + 1'b1 : '0;

  firpow_ram #(
    .WIDTH (COEF_W),
    .DEPTH (TAP_COUNT)
  ) u_coef_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_ext[TAP_W-1:0]),
    .wdata (coef_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // unwritten entries read as zero
  assign coef_eff = cv_q_r ? $signed(rdata) : '0;
  assign mult     = $signed({1'b0, dl_r[0]}) * coef_eff;

  // delay line: shift on a new sample, rotate one tap per cycle during the pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TAP_COUNT; k++) dl_r[k] <= '0;
    end else if (ctl.load) begin
      dl_r[0] <= sample;
      for (int k = 1; k < TAP_COUNT; k++) dl_r[k] <= dl_r[k-1];
    end else if (run_r) begin
      for (int k = 0; k < TAP_COUNT - 1; k++) dl_r[k] <= dl_r[k+1];
      dl_r[TAP_COUNT-1] <= dl_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r    <= '0;
      cv_q_r  <= 1'b0;
      run_r   <= 1'b0;
      drain_r <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (wr_en) begin
        cv_r[idx_ext[TAP_W-1:0]] <= 1'b1;
      end
      cv_q_r  <= cv_r[raddr];
      done_r  <= drain_r;
      drain_r <= 1'b0;
      if (ctl.load) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == LAST_TAP) begin
          run_r   <= 1'b0;
          drain_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod_r <= '0;
      acc_r  <= '0;
    end else if (run_r || drain_r) begin
      prod_r <= mult;
      acc_r  <= acc_r + ACC_W'(prod_r);
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

[rtl/firpow_sqr.sv]
// Bit-serial squarer with 32-bit saturation: one multiplier bit per cycle.
// Depends on firpow_pkg.
module firpow_sqr (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [firpow_pkg::MAG_W-1:0]   mag,
  output logic                           done,
  output logic [firpow_pkg::POWER_W-1:0] power,
  output logic                           power_sat
);
  import firpow_pkg::*;

  localparam int CNT_W = $clog2(MAG_W);
  localparam int LOW_HI = POWER_W - MAG_W;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAG_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [MAG_W-1:0] mcand_r;
  logic [MAG_W-1:0] hi_r;
  logic [MAG_W-1:0] lo_r;
  logic [MAG_W:0]   sum;

  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mag;
      lo_r    <= mag;
      hi_r    <= '0;
    end else if (busy_r) begin
      hi_r <= sum[MAG_W:1];
      lo_r <= {sum[0], lo_r[MAG_W-1:1]};
    end
  end

  assign done      = done_r;
  assign power_sat = |hi_r[MAG_W-1:LOW_HI];
  assign power     = power_sat ? '1 : {hi_r[LOW_HI-1:0], lo_r};

endmodule

[rtl/fir_filter_with_power_output.sv]
// Direct-form FIR filter over unsigned 12-bit samples with a power output.
// A mode 0 transaction shifts its sample into a HIGHEST_TAP+1 tap delay line
// (newest at tap 0, cleared at reset) and yields one result: the full-precision
// sum of tap times signed Q1.15 coefficient, floored by 2^15 and clamped to 18
// bits, plus its square clamped to 32 bits with a flag. A mode 1 transaction
// writes one coefficient (indexes past the last tap are dropped) and yields
// nothing; coefficients read as zero until written. Once a sample is accepted,
// no further transaction is taken until its result reaches the output stage:
// one shared multiply-accumulate visits one tap per cycle, then a bit-serial
// squarer works through the 18-bit magnitude. The finished result sits in an
// output register, so a new transaction is taken while it waits for the sink.
// Depends on firpow_pkg, firpow_if, firpow_ram, firpow_mac, firpow_sqr.
module fir_filter_with_power_output #(
  parameter int HIGHEST_TAP = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  firpow_in_if.sink    in_chan,
  firpow_out_if.source out_chan
);
  import firpow_pkg::*;

  localparam int TAP_W = $clog2(HIGHEST_TAP + 1);
  localparam int ACC_W = PROD_W + TAP_W;
  localparam int CMP_W = (ACC_W > FILT_W) ? ACC_W : FILT_W;
  localparam logic signed [CMP_W-1:0] FMAX_C = CMP_W'(FILT_MAX);
  localparam logic signed [CMP_W-1:0] FMIN_C = CMP_W'(FILT_MIN);

  // controller states
  localparam logic [2:0] ST_IDLE = 3'd0;  // taking transactions
  localparam logic [2:0] ST_MAC  = 3'd1;  // tap pass running
  localparam logic [2:0] ST_FILT = 3'd2;  // scale and clamp the sum
  localparam logic [2:0] ST_SQST = 3'd3;  // kick the squarer
  localparam logic [2:0] ST_SQW  = 3'd4;  // squarer running
  localparam logic [2:0] ST_DONE = 3'd5;  // wait for a free output register

  logic [2:0]               state_r, state_nxt;
  logic signed [FILT_W-1:0] filt_r, filt_nxt;
  logic                     out_valid_r;
  logic signed [FILT_W-1:0] out_filt_r;
  logic [POWER_W-1:0]       out_pow_r;
  logic                     out_sat_r;

  logic                     in_fire;
  logic                     out_free;
  logic                     load_out;
  mac_ctl_t                 mac_ctl;
  logic                     mac_done;
  logic signed [ACC_W-1:0]  acc;
  logic signed [CMP_W-1:0]  scaled;
  logic [MAG_W-1:0]         mag;
  logic                     sq_start;
  logic                     sq_done;
  logic [POWER_W-1:0]       sq_power;
  logic                     sq_sat;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign mac_ctl.load  = in_fire && (in_chan.mode == MODE_FILTER);
  assign mac_ctl.wr_en = in_fire && (in_chan.mode == MODE_COEF);

  firpow_mac #(
    .HIGHEST_TAP (HIGHEST_TAP)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mac_ctl),
    .sample     (in_chan.sample),
    .coef_index (in_chan.coef_index),
    .coef_value (in_chan.coef_value),
    .done       (mac_done),
    .acc        (acc)
  );

  // arithmetic shift gives floor; clamp only bites with long filters
  assign scaled = CMP_W'(acc >>> FRAC_BITS);

  always_comb begin
    if (scaled > FMAX_C) begin
      filt_nxt = FILT_W'(FMAX_C);
    end else if (scaled < FMIN_C) begin
      filt_nxt = FILT_W'(FMIN_C);
    end else begin
      filt_nxt = scaled[FILT_W-1:0];
    end
  end

  // magnitude of -2^17 still fits in 18 unsigned bits
  assign mag      = filt_r[FILT_W-1] ? MAG_W'(-filt_r) : MAG_W'(filt_r);
  assign sq_start = (state_r == ST_SQST);

  firpow_sqr u_sqr (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (sq_start),
    .mag       (mag),
    .done      (sq_done),
    .power     (sq_power),
    .power_sat (sq_sat)
  );

  assign out_free = !out_valid_r || out_chan.ready;
  assign load_out = (state_r == ST_DONE) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (mac_ctl.load) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          state_nxt = ST_FILT;
        end
      end
      ST_FILT: state_nxt = ST_SQST;
      ST_SQST: state_nxt = ST_SQW;
      ST_SQW: begin
        if (sq_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FILT) begin
      filt_r <= filt_nxt;
    end
    if (load_out) begin
      out_filt_r <= filt_r;
      out_pow_r  <= sq_power;
      out_sat_r  <= sq_sat;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.filtered        = out_filt_r;
  assign out_chan.power           = out_pow_r;
  assign out_chan.power_saturated = out_sat_r;

`ifndef ASSERT_OFF
  // a result only appears after the full sample pipeline has finished
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside DONE");

  // a coefficient transaction never starts a pass
  a_coef_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    mac_ctl.wr_en |=> state_r == ST_IDLE)
    else $error("coefficient write left IDLE");

  // the tap pass only completes while the controller waits for it
  a_mac_align: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == ST_MAC)
    else $error("MAC finished out of step");

  // clamp flag and clamped power agree
  a_sat_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sat_r |-> &out_pow_r)
    else $error("saturated power not all ones");

  // zero output implies zero power
  a_zero_pow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_filt_r == '0 |-> out_pow_r == '0 && !out_sat_r)
    else $error("nonzero power for zero output");
`endif

endmodule
